// ===== design/sce_pkg.sv =====
// ----------------------------------------------------------------------------
// sce_pkg
// Shared types, codes and constants of the solenoid click effect sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

    // Field widths of the item, the result and the configuration port.
    localparam int unsigned OP_W       = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SRC_W      = 2;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned PHASE_W    = 3;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned IVL_W      = 4;
    localparam int unsigned GAP_W      = 8;
    localparam int unsigned PULSE_W    = 10;
    localparam int unsigned TIMER_W    = 8;
    localparam int unsigned SINCE_W    = 16;

    // Piston travel end point.
    localparam int unsigned POSITION_MAX = 15;
    localparam int unsigned POS_STEP     = 5;

    // Item operations.
    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_BYTE    = 2'd1;
    localparam logic [OP_W-1:0] OP_TRIGGER = 2'd2;

    // Byte sources.
    localparam logic [SRC_W-1:0] SRC_ABSENT = 2'd0;
    localparam logic [SRC_W-1:0] SRC_I2C    = 2'd3;

    // Command bytes.
    localparam logic [BYTE_W-1:0] CMD_SKIP_TWO = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_SKIP_ONE = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_FIRE     = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_FIRE_ALT = 8'h11;

    // Fire mode codes reported on the result.
    localparam logic [MODE_W-1:0] MODE_NO_FIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAST    = 2'd2;

    // Phase codes reported on the result.
    localparam logic [PHASE_W-1:0] PCODE_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PCODE_FWD   = 3'd1;
    localparam logic [PHASE_W-1:0] PCODE_BACK  = 3'd2;
    localparam logic [PHASE_W-1:0] PCODE_FAST1 = 3'd3;
    localparam logic [PHASE_W-1:0] PCODE_FAST2 = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_GAP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_ENABLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_STRENGTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VIB_PULSE      = 3'd5;

    // Configuration reset values.
    localparam logic [7:0]         RST_FAST_THRESHOLD = 8'd30;
    localparam logic [IVL_W-1:0]   RST_STEP_INTERVAL  = 4'd3;
    localparam logic [GAP_W-1:0]   RST_FAST_GAP       = 8'd16;
    localparam logic               RST_VIB_ENABLE     = 1'b1;
    localparam logic [LEVEL_W-1:0] RST_VIB_STRENGTH   = 8'd180;
    localparam logic [PULSE_W-1:0] RST_VIB_PULSE      = 10'd45;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_FWD   = 5'b00010,
        PH_BACK  = 5'b00100,
        PH_FAST1 = 5'b01000,
        PH_FAST2 = 5'b10000
    } t_phase;

    typedef enum logic [3:0] {
        FR_HDR       = 4'b0001,
        FR_SKIP_TWO  = 4'b0010,
        FR_SKIP_LAST = 4'b0100,
        FR_SKIP_ONE  = 4'b1000
    } t_frame;

    typedef struct packed {
        logic [7:0]         fast_threshold;
        logic [IVL_W-1:0]   step_interval;
        logic [GAP_W-1:0]   fast_gap;
        logic               vib_enable;
        logic [LEVEL_W-1:0] vib_strength;
        logic [PULSE_W-1:0] vib_pulse;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] byte_value;
        logic [SRC_W-1:0]  source;
    } t_item;

    typedef struct packed {
        logic               click;
        logic [LEVEL_W-1:0] vib_level;
        logic [POS_W-1:0]   piston_pos;
        logic [PHASE_W-1:0] seq_phase;
        logic [SRC_W-1:0]   active_src;
        logic [MODE_W-1:0]  fired_mode;
    } t_result;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_FWD:   code = PCODE_FWD;
            PH_BACK:  code = PCODE_BACK;
            PH_FAST1: code = PCODE_FAST1;
            PH_FAST2: code = PCODE_FAST2;
            default:  code = PCODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== design/sce_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// sce_cfg_regs
// Configuration register file; a write lands at the indexed register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_cfg_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output sce_pkg::t_cfg                          o_cfg
);

    sce_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fast_threshold <= sce_pkg::RST_FAST_THRESHOLD;
            r_cfg.step_interval  <= sce_pkg::RST_STEP_INTERVAL;
            r_cfg.fast_gap       <= sce_pkg::RST_FAST_GAP;
            r_cfg.vib_enable     <= sce_pkg::RST_VIB_ENABLE;
            r_cfg.vib_strength   <= sce_pkg::RST_VIB_STRENGTH;
            r_cfg.vib_pulse      <= sce_pkg::RST_VIB_PULSE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sce_pkg::CFG_FAST_THRESHOLD: r_cfg.fast_threshold <= i_cfg_data[7:0];
                sce_pkg::CFG_STEP_INTERVAL:
                    r_cfg.step_interval <= i_cfg_data[sce_pkg::IVL_W-1:0];
                sce_pkg::CFG_FAST_GAP:       r_cfg.fast_gap <= i_cfg_data[sce_pkg::GAP_W-1:0];
                sce_pkg::CFG_VIB_ENABLE:     r_cfg.vib_enable <= i_cfg_data[0];
                sce_pkg::CFG_VIB_STRENGTH:
                    r_cfg.vib_strength <= i_cfg_data[sce_pkg::LEVEL_W-1:0];
                sce_pkg::CFG_VIB_PULSE:      r_cfg.vib_pulse <= i_cfg_data[sce_pkg::PULSE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/sce_in_stage.sv =====
// ----------------------------------------------------------------------------
// sce_in_stage
// Input register stage; holds one item until the engine takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire sce_pkg::t_item i_item,
    input  wire logic           i_take_ok,
    output logic                o_take,
    output sce_pkg::t_item      o_item
);

    logic           r_valid;
    sce_pkg::t_item r_item;
    logic           accept;

    assign o_take  = r_valid && i_take_ok;
    assign o_stall = r_valid && !i_take_ok;
    assign accept  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/sce_engine.sv =====
// ----------------------------------------------------------------------------
// sce_engine
// Effect state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sce_engine #(
    parameter int unsigned POSITION_MAX = sce_pkg::POSITION_MAX
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_take,
    input  wire sce_pkg::t_item i_item,
    input  wire sce_pkg::t_cfg  i_cfg,
    output sce_pkg::t_result    o_result
);

    sce_pkg::t_phase                  r_phase, n_phase;
    sce_pkg::t_frame                  r_frame, n_frame;
    logic [sce_pkg::POS_W-1:0]        r_pos, n_pos;
    logic [sce_pkg::TIMER_W-1:0]      r_timer, n_timer;
    logic [sce_pkg::SINCE_W-1:0]      r_since, n_since;
    logic                             r_vib_active, n_vib_active;
    logic [sce_pkg::PULSE_W-1:0]      r_vib_rem, n_vib_rem;
    logic [sce_pkg::SRC_W-1:0]        r_last_src, n_last_src;

    always_comb begin
        logic                            click;
        logic                            fire;
        logic                            force_normal;
        logic [sce_pkg::MODE_W-1:0]      mode;
        logic [sce_pkg::POS_W:0]         pos_up;
        logic [sce_pkg::TIMER_W-1:0]     ivl;
        logic [sce_pkg::TIMER_W-1:0]     gap;

        n_phase      = r_phase;
        n_frame      = r_frame;
        n_pos        = r_pos;
        n_timer      = r_timer;
        n_since      = r_since;
        n_vib_active = r_vib_active;
        n_vib_rem    = r_vib_rem;
        n_last_src   = r_last_src;
        click        = 1'b0;
        fire         = 1'b0;
        force_normal = 1'b0;
        mode         = sce_pkg::MODE_NO_FIRE;
        ivl          = {{(sce_pkg::TIMER_W-sce_pkg::IVL_W){1'b0}}, i_cfg.step_interval};
        gap          = i_cfg.fast_gap;
        pos_up       = {1'b0, r_pos} + (sce_pkg::POS_W+1)'(sce_pkg::POS_STEP);

        case (i_item.op)
            sce_pkg::OP_TICK: begin
                if (r_since != '1) begin
                    n_since = r_since + 1'b1;
                end
                if (r_vib_active) begin
                    if (r_vib_rem != '0) begin
                        n_vib_rem = r_vib_rem - 1'b1;
                    end
                    if (n_vib_rem == '0) begin
                        n_vib_active = 1'b0;
                    end
                end
                if (r_timer != '1) begin
                    n_timer = r_timer + 1'b1;
                end
                case (r_phase)
                    sce_pkg::PH_FWD: begin
                        if (n_timer >= ivl) begin
                            n_timer = n_timer - ivl;
                            if (pos_up >= (sce_pkg::POS_W+1)'(POSITION_MAX)) begin
                                n_pos   = sce_pkg::POS_W'(POSITION_MAX);
                                click   = 1'b1;
                                n_phase = sce_pkg::PH_BACK;
                            end else begin
                                n_pos = pos_up[sce_pkg::POS_W-1:0];
                            end
                        end
                    end
                    sce_pkg::PH_BACK: begin
                        if (n_timer >= ivl) begin
                            n_timer = n_timer - ivl;
                            if (r_pos <= sce_pkg::POS_W'(sce_pkg::POS_STEP)) begin
                                n_pos   = '0;
                                n_phase = sce_pkg::PH_IDLE;
                            end else begin
                                n_pos = r_pos - sce_pkg::POS_W'(sce_pkg::POS_STEP);
                            end
                        end
                    end
                    sce_pkg::PH_FAST1: begin
                        if (n_timer >= gap) begin
                            click   = 1'b1;
                            n_phase = sce_pkg::PH_FAST2;
                            n_timer = '0;
                        end
                    end
                    sce_pkg::PH_FAST2: begin
                        if (n_timer >= gap) begin
                            n_phase = sce_pkg::PH_IDLE;
                        end
                    end
                    default: n_phase = sce_pkg::PH_IDLE;
                endcase
            end
            sce_pkg::OP_BYTE: begin
                if (i_item.source != sce_pkg::SRC_ABSENT) begin
                    n_last_src = i_item.source;
                    if (i_item.source == sce_pkg::SRC_I2C) begin
                        fire = (i_item.byte_value == sce_pkg::CMD_FIRE);
                    end else begin
                        // USB and Bluetooth bytes walk the framing parser.
                        case (r_frame)
                            sce_pkg::FR_HDR: begin
                                case (i_item.byte_value)
                                    sce_pkg::CMD_SKIP_TWO: n_frame = sce_pkg::FR_SKIP_TWO;
                                    sce_pkg::CMD_SKIP_ONE: n_frame = sce_pkg::FR_SKIP_ONE;
                                    sce_pkg::CMD_FIRE, sce_pkg::CMD_FIRE_ALT: fire = 1'b1;
                                    default: ;
                                endcase
                            end
                            sce_pkg::FR_SKIP_TWO: n_frame = sce_pkg::FR_SKIP_LAST;
                            default:              n_frame = sce_pkg::FR_HDR;
                        endcase
                    end
                end
            end
            sce_pkg::OP_TRIGGER: force_normal = 1'b1;
            default: ;
        endcase

        if (fire) begin
            // A fire inside the threshold window takes the fast double click.
            n_since = '0;
            if (r_since < {{(sce_pkg::SINCE_W-8){1'b0}}, i_cfg.fast_threshold}) begin
                click   = 1'b1;
                n_phase = sce_pkg::PH_FAST1;
                n_timer = '0;
                mode    = sce_pkg::MODE_FAST;
            end else begin
                force_normal = 1'b1;
            end
        end

        if (force_normal) begin
            click   = 1'b1;
            n_pos   = '0;
            n_phase = sce_pkg::PH_FWD;
            n_timer = '0;
            mode    = sce_pkg::MODE_NORMAL;
        end

        if (click && i_cfg.vib_enable && (i_cfg.vib_pulse != '0)) begin
            n_vib_active = 1'b1;
            n_vib_rem    = i_cfg.vib_pulse;
        end

        o_result.click      = click;
        o_result.vib_level  = n_vib_active ? i_cfg.vib_strength : '0;
        o_result.piston_pos = n_pos;
        o_result.seq_phase  = sce_pkg::phase_code(n_phase);
        o_result.active_src = n_last_src;
        o_result.fired_mode = mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= sce_pkg::PH_IDLE;
            r_frame      <= sce_pkg::FR_HDR;
            r_pos        <= '0;
            r_timer      <= '0;
            r_since      <= '1;
            r_vib_active <= 1'b0;
            r_vib_rem    <= '0;
            r_last_src   <= sce_pkg::SRC_ABSENT;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_frame      <= n_frame;
            r_pos        <= n_pos;
            r_timer      <= n_timer;
            r_since      <= n_since;
            r_vib_active <= n_vib_active;
            r_vib_rem    <= n_vib_rem;
            r_last_src   <= n_last_src;
        end
    end

endmodule

`default_nettype wire

// ===== design/solenoid_click_effect_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// solenoid_click_effect_sequencer_core
// Each item (a 1 ms tick, a received command byte or a local trigger) gives
// exactly one result. An item is registered on entry, updates the effect state
// in a single combinational pass and lands in the output register, so one item
// per cycle is sustained while the output is not stalled; the result is valid
// once the item leaves the input register and its result is loaded into the output register.
// The input side stalls only while its register is full and the output
// register holds a result that is itself stalled. Configuration writes are
// always ready and should be made while no item is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module solenoid_click_effect_sequencer_core #(
    parameter int unsigned POSITION_MAX = sce_pkg::POSITION_MAX
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Item channel.
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [sce_pkg::OP_W-1:0]         i_op,
    input  wire logic [sce_pkg::BYTE_W-1:0]       i_byte_value,
    input  wire logic [sce_pkg::SRC_W-1:0]        i_source,
    // Result channel.
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic                                  o_click,
    output logic [sce_pkg::LEVEL_W-1:0]           o_vib_level,
    output logic [sce_pkg::POS_W-1:0]             o_piston_pos,
    output logic [sce_pkg::PHASE_W-1:0]           o_seq_phase,
    output logic [sce_pkg::SRC_W-1:0]             o_active_src,
    output logic [sce_pkg::MODE_W-1:0]            o_fired_mode,
    // Configuration write channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [sce_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sce_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    sce_pkg::t_cfg    cfg;
    sce_pkg::t_item   in_item;
    sce_pkg::t_item   stage_item;
    sce_pkg::t_result result;
    logic             take;
    logic             out_load_ok;
    logic             r_out_valid;
    sce_pkg::t_result r_out;

    assign in_item.op         = i_op;
    assign in_item.byte_value = i_byte_value;
    assign in_item.source     = i_source;

    assign out_load_ok = !r_out_valid || !i_out_stall;

    sce_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sce_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (in_item),
        .i_take_ok (out_load_ok),
        .o_take    (take),
        .o_item    (stage_item)
    );

    sce_engine #(
        .POSITION_MAX (POSITION_MAX)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (stage_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_click      = r_out.click;
    assign o_vib_level  = r_out.vib_level;
    assign o_piston_pos = r_out.piston_pos;
    assign o_seq_phase  = r_out.seq_phase;
    assign o_active_src = r_out.active_src;
    assign o_fired_mode = r_out.fired_mode;

endmodule

`default_nettype wire
